// File: src/esc_pkg.sv
// shared types and constants for the sensor compensation pipeline
// used by esc_front, esc_div, esc_back and the top level in src; no dependencies
package esc_pkg;

  localparam int CFG_IW    = 3;
  localparam int DIV_STEPS = 64;

  localparam logic [CFG_IW-1:0] REG_TEMP       = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PRESS_NINE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HUM        = 3'd4;
  localparam logic [CFG_IW-1:0] REG_HUM_ONE    = 3'd5;

  localparam logic signed [32:0] PRESS_OFFSET = 33'sd128000;
  localparam logic [20:0]        RAW_P_FULL   = 21'd1048576;
  localparam logic [63:0]        PRESS_SCALE  = 64'd3125;
  localparam logic signed [32:0] HUM_OFFSET   = 33'sd76800;
  localparam logic signed [63:0] HUM_LIMIT    = 64'sd419430400;
  localparam logic [16:0]        HUM_MAX      = 17'd102400;
  localparam logic signed [49:0] HUM_ROUND_A  = 50'sd16384;
  localparam logic signed [63:0] HUM_BIAS_B   = 64'sd2097152;
  localparam logic [63:0]        HUM_ROUND_B  = 64'd8192;
  localparam logic signed [31:0] HUM_BIAS_C   = 32'sd32768;
  localparam logic [63:0]        DIVISOR_BIAS = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } coeff_t;

  typedef struct packed {
    logic signed [31:0] tf;
    logic signed [31:0] tc;
    logic        [16:0] hum;
  } side_t;

endpackage

// File: src/esc_mul64.sv
// two-stage multiplier keeping the low 64 bits of a 64 x 64 product
// built from three 32 x 32 partial products; no dependencies
module esc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);

  logic [63:0] ll;
  logic [31:0] hl;
  logic [31:0] lh;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[31:0] * b[31:0];
      hl <= a[63:32] * b[31:0];
      lh <= a[31:0] * b[63:32];
      y  <= ll + {hl + lh, 32'b0};
    end
  end

endmodule

// File: src/esc_front.sv
// temperature, pressure divisor/dividend and humidity pipeline, 17 stages
// depends on esc_pkg and esc_mul64
module esc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [19:0]         raw_t,
  input  logic [19:0]         raw_p,
  input  logic [15:0]         raw_h,
  input  esc_pkg::coeff_t     coeff,
  output logic                o_vld,
  output logic signed [63:0]  num,
  output logic signed [31:0]  dv,
  output esc_pkg::side_t      side
);
  import esc_pkg::*;

  logic [17:1]        vld;
  logic [19:0]        t1r;
  logic [19:0]        pr_d [1:8];
  logic [15:0]        hr_d [1:5];
  logic signed [17:0] tx;
  logic signed [17:0] td;
  logic signed [33:0] ta2;
  logic signed [35:0] tdd2;
  logic signed [23:0] tdd_s;
  logic signed [22:0] ta3;
  logic signed [39:0] tb3;
  logic signed [26:0] tsum;
  logic signed [31:0] tf_d [4:17];
  logic signed [31:0] tc_d [5:17];
  logic signed [32:0] pa;
  logic signed [32:0] hv;
  logic signed [35:0] tc_full;
  logic signed [63:0] paa5;
  logic signed [48:0] pap5_d [5:7];
  logic signed [48:0] pap2_d [5:7];
  logic signed [48:0] hh5;
  logic signed [40:0] hv6;
  logic signed [41:0] hv3;
  logic signed [49:0] ha_sum;
  logic signed [34:0] ha_d [6:10];
  logic signed [30:0] hv6s;
  logic signed [31:0] hv3s;
  logic signed [63:0] hb1;
  logic [63:0]        b7;
  logic signed [63:0] apre7;
  logic signed [63:0] hb2;
  logic [20:0]        pfull;
  logic [63:0]        num0;
  logic signed [49:0] hb3;
  logic signed [31:0] dv_d [11:17];
  logic [63:0]        num_d [12:17];
  logic [63:0]        v_d [13:16];
  logic signed [63:0] hfin;
  logic [16:0]        hum17;
  logic [63:0]        m_p6, m_p3, m_p1, m_h2, m_num, m_v, m_dd, m_h1;

  always_comb begin
    tx      = $signed({1'b0, t1r[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
    td      = $signed({2'b0, t1r[19:4]}) - $signed({2'b0, coeff.t1});
    tdd_s   = 24'(tdd2 >>> 12);
    tsum    = {{4{ta3[22]}}, ta3} + 27'(tb3 >>> 14);
    pa      = $signed({tf_d[4][31], tf_d[4]}) - PRESS_OFFSET;
    hv      = $signed({tf_d[4][31], tf_d[4]}) - HUM_OFFSET;
    tc_full = $signed({{4{tf_d[4][31]}}, tf_d[4]}) * 36'sd5 + 36'sd128;
    ha_sum  = $signed({20'b0, hr_d[5], 14'b0})
            - $signed({{14{coeff.h4[15]}}, coeff.h4, 20'b0})
            - hh5 + HUM_ROUND_A;
    hv6s    = 31'(hv6 >>> 10);
    hv3s    = 32'(hv3 >>> 11) + HUM_BIAS_C;
    pfull   = RAW_P_FULL - {1'b0, pr_d[8]};
    hfin    = $signed(v_d[16]) - ($signed(m_h1) >>> 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[16:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature
      t1r      <= raw_t;
      pr_d[1]  <= raw_p;
      hr_d[1]  <= raw_h;
      for (int i = 2; i <= 8; i++) pr_d[i] <= pr_d[i-1];
      for (int i = 2; i <= 5; i++) hr_d[i] <= hr_d[i-1];
      ta2      <= tx * $signed(coeff.t2);
      tdd2     <= td * td;
      ta3      <= 23'(ta2 >>> 11);
      tb3      <= tdd_s * $signed(coeff.t3);
      tf_d[4]  <= 32'(tsum);
      for (int i = 5; i <= 17; i++) tf_d[i] <= tf_d[i-1];
      tc_d[5]  <= 32'(tc_full >>> 8);
      for (int i = 6; i <= 17; i++) tc_d[i] <= tc_d[i-1];
      // pressure and humidity products
      paa5      <= pa * pa;
      pap5_d[5] <= pa * $signed(coeff.p5);
      pap2_d[5] <= pa * $signed(coeff.p2);
      pap5_d[6] <= pap5_d[5];
      pap2_d[6] <= pap2_d[5];
      pap5_d[7] <= pap5_d[6];
      pap2_d[7] <= pap2_d[6];
      hh5       <= hv * $signed(coeff.h5);
      hv6       <= hv * $signed(coeff.h6);
      hv3       <= hv * $signed({1'b0, coeff.h3});
      ha_d[6]   <= 35'(ha_sum >>> 15);
      for (int i = 7; i <= 10; i++) ha_d[i] <= ha_d[i-1];
      hb1       <= hv6s * hv3s;
      b7        <= m_p6 + {pap5_d[7][46:0], 17'b0}
                 + {{13{coeff.p4[15]}}, coeff.p4, 35'b0};
      apre7     <= ($signed(m_p3) >>> 8) + $signed({{3{pap2_d[7][48]}}, pap2_d[7], 12'b0});
      hb2       <= (hb1 >>> 10) + HUM_BIAS_B;
      num0      <= {12'b0, pfull, 31'b0} - b7;
      dv_d[11]  <= 32'($signed(m_p1) >>> 33);
      for (int i = 12; i <= 17; i++) dv_d[i] <= dv_d[i-1];
      hb3       <= 50'($signed(m_h2 + HUM_ROUND_B) >>> 14);
      num_d[12] <= m_num;
      for (int i = 13; i <= 17; i++) num_d[i] <= num_d[i-1];
      v_d[13]   <= m_v;
      for (int i = 14; i <= 16; i++) v_d[i] <= v_d[i-1];
      // humidity clamp
      if (hfin[63]) begin
        hum17 <= '0;
      end else if (hfin > HUM_LIMIT) begin
        hum17 <= HUM_MAX;
      end else begin
        hum17 <= hfin[28:12];
      end
    end
  end

  esc_mul64 u_mul_p6 (.clk(clk), .en(adv), .a(paa5),
    .b({{48{coeff.p6[15]}}, coeff.p6}), .y(m_p6));
  esc_mul64 u_mul_p3 (.clk(clk), .en(adv), .a(paa5),
    .b({{48{coeff.p3[15]}}, coeff.p3}), .y(m_p3));
  esc_mul64 u_mul_p1 (.clk(clk), .en(adv), .a(apre7 + DIVISOR_BIAS),
    .b({48'b0, coeff.p1}), .y(m_p1));
  esc_mul64 u_mul_h2 (.clk(clk), .en(adv), .a(hb2),
    .b({{48{coeff.h2[15]}}, coeff.h2}), .y(m_h2));
  esc_mul64 u_mul_num (.clk(clk), .en(adv), .a(num0), .b(PRESS_SCALE), .y(m_num));
  esc_mul64 u_mul_v (.clk(clk), .en(adv), .a({{29{ha_d[10][34]}}, ha_d[10]}),
    .b({{14{hb3[49]}}, hb3}), .y(m_v));
  esc_mul64 u_mul_dd (.clk(clk), .en(adv), .a($signed(m_v) >>> 15),
    .b($signed(m_v) >>> 15), .y(m_dd));
  esc_mul64 u_mul_h1 (.clk(clk), .en(adv), .a($signed(m_dd) >>> 7),
    .b({56'b0, coeff.h1}), .y(m_h1));

  assign o_vld    = vld[17];
  assign num      = $signed(num_d[17]);
  assign dv       = dv_d[17];
  assign side.tf  = tf_d[17];
  assign side.tc  = tc_d[17];
  assign side.hum = hum17;

endmodule

// File: src/esc_div.sv
// signed 64 / 32 divide, truncating, one quotient bit per pipeline stage
// depends on esc_pkg
module esc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [63:0] num,
  input  logic signed [31:0] dv,
  input  esc_pkg::side_t     side_in,
  output logic               o_vld,
  output logic signed [63:0] quo,
  output logic               zero,
  output esc_pkg::side_t     side
);
  import esc_pkg::*;

  logic        vld [0:DIV_STEPS];
  logic [63:0] q   [0:DIV_STEPS];
  logic [31:0] r   [0:DIV_STEPS];
  logic [31:0] mb  [0:DIV_STEPS];
  logic        neg [0:DIV_STEPS];
  logic        zer [0:DIV_STEPS];
  side_t       sd  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q[0]   <= num[63] ? -num : num;
      mb[0]  <= dv[31] ? -dv : dv;
      r[0]   <= '0;
      neg[0] <= num[63] ^ dv[31];
      zer[0] <= (dv == '0);
      sd[0]  <= side_in;
    end
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {r[i-1], q[i-1][63]};
    assign diff  = trial - {1'b0, mb[i-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[32]) begin
          r[i] <= diff[31:0];
          q[i] <= {q[i-1][62:0], 1'b1};
        end else begin
          r[i] <= trial[31:0];
          q[i] <= {q[i-1][62:0], 1'b0};
        end
        mb[i]  <= mb[i-1];
        neg[i] <= neg[i-1];
        zer[i] <= zer[i-1];
        sd[i]  <= sd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quo  <= neg[DIV_STEPS] ? -$signed(q[DIV_STEPS]) : $signed(q[DIV_STEPS]);
      zero <= zer[DIV_STEPS];
      side <= sd[DIV_STEPS];
    end
  end

endmodule

// File: src/esc_back.sv
// pressure correction after the divide, saturation and output register
// depends on esc_pkg and esc_mul64
module esc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [63:0] p,
  input  logic               zero,
  input  esc_pkg::side_t     side_in,
  input  esc_pkg::coeff_t    coeff,
  output logic               o_vld,
  output logic signed [31:0] fine_temperature,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_valid,
  output logic [16:0]        humidity_q22_10
);
  import esc_pkg::*;

  logic [6:1]         vld;
  logic signed [63:0] ps;
  logic signed [63:0] p_d  [1:4];
  logic signed [63:0] ps_d [1:2];
  logic               zero_d [1:5];
  side_t              sd [1:5];
  logic signed [63:0] b2_3;
  logic signed [63:0] b2_4;
  logic signed [63:0] pf5;
  logic [63:0]        m1, m2, m3;

  assign ps = p >>> 13;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_d[1]    <= p;
      for (int i = 2; i <= 4; i++) p_d[i] <= p_d[i-1];
      ps_d[1]   <= ps;
      ps_d[2]   <= ps_d[1];
      zero_d[1] <= zero;
      sd[1]     <= side_in;
      for (int i = 2; i <= 5; i++) begin
        zero_d[i] <= zero_d[i-1];
        sd[i]     <= sd[i-1];
      end
      b2_3 <= $signed(m2) >>> 19;
      b2_4 <= b2_3;
      pf5  <= ((p_d[4] + ($signed(m3) >>> 25) + b2_4) >>> 8)
            + $signed({{44{coeff.p7[15]}}, coeff.p7, 4'b0});
      // saturation to the unsigned 32-bit range
      if (zero_d[5] || pf5[63]) begin
        pressure_q24_8 <= '0;
      end else if (pf5[63:32] != '0) begin
        pressure_q24_8 <= '1;
      end else begin
        pressure_q24_8 <= pf5[31:0];
      end
      pressure_valid    <= !zero_d[5];
      fine_temperature  <= sd[5].tf;
      temperature_centi <= sd[5].tc;
      humidity_q22_10   <= sd[5].hum;
    end
  end

  esc_mul64 u_mul_p9 (.clk(clk), .en(adv), .a({{48{coeff.p9[15]}}, coeff.p9}),
    .b(ps), .y(m1));
  esc_mul64 u_mul_p8 (.clk(clk), .en(adv), .a({{48{coeff.p8[15]}}, coeff.p8}),
    .b(p), .y(m2));
  esc_mul64 u_mul_sq (.clk(clk), .en(adv), .a(m1), .b(ps_d[2]), .y(m3));

  assign o_vld = vld[6];

endmodule

// File: src/env_sensor_compensation_top.sv
// top level of the sensor compensation pipeline: coefficient registers and stall control
// depends on esc_pkg, esc_front, esc_div, esc_back
//
//   channel | direction | signals
//   in      | sink      | in_valid, in_ready, raw_temperature, raw_pressure, raw_humidity
//   out     | source    | out_valid, out_ready, fine_temperature .. humidity_q22_10
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one transfer per cycle in and out while out_ready does not hold the pipeline; 17 front stages,
// 66 divider stages (64 of them at one quotient bit each), 6 back stages
// synchronous reset clears valid bits and coefficients; cfg_ready is always high
// the whole pipeline holds while a result waits on out_ready low
module env_sensor_compensation_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [19:0]                raw_temperature,
  input  logic [19:0]                raw_pressure,
  input  logic [15:0]                raw_humidity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         fine_temperature,
  output logic signed [31:0]         temperature_centi,
  output logic [31:0]                pressure_q24_8,
  output logic                       pressure_valid,
  output logic [16:0]                humidity_q22_10,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [esc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_data
);
  import esc_pkg::*;

  logic [47:0]        temp_coeffs;
  logic [63:0]        press_coeffs_low;
  logic [63:0]        press_coeffs_high;
  logic [15:0]        press_coeff_nine;
  logic [63:0]        hum_coeffs;
  logic [7:0]         hum_coeff_one;
  coeff_t             coeff;
  logic               adv;
  logic               f_vld;
  logic signed [63:0] f_num;
  logic signed [31:0] f_dv;
  side_t              f_side;
  logic               d_vld;
  logic signed [63:0] d_quo;
  logic               d_zero;
  side_t              d_side;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
      hum_coeffs        <= '0;
      hum_coeff_one     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEMP:       temp_coeffs       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_coeffs_low  <= cfg_data;
        REG_PRESS_HIGH: press_coeffs_high <= cfg_data;
        REG_PRESS_NINE: press_coeff_nine  <= cfg_data[15:0];
        REG_HUM:        hum_coeffs        <= cfg_data;
        REG_HUM_ONE:    hum_coeff_one     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coeff.t1 = temp_coeffs[15:0];
    coeff.t2 = temp_coeffs[31:16];
    coeff.t3 = temp_coeffs[47:32];
    coeff.p1 = press_coeffs_low[15:0];
    coeff.p2 = press_coeffs_low[31:16];
    coeff.p3 = press_coeffs_low[47:32];
    coeff.p4 = press_coeffs_low[63:48];
    coeff.p5 = press_coeffs_high[15:0];
    coeff.p6 = press_coeffs_high[31:16];
    coeff.p7 = press_coeffs_high[47:32];
    coeff.p8 = press_coeffs_high[63:48];
    coeff.p9 = press_coeff_nine;
    coeff.h1 = hum_coeff_one;
    coeff.h2 = hum_coeffs[15:0];
    coeff.h3 = hum_coeffs[23:16];
    coeff.h4 = hum_coeffs[39:24];
    coeff.h5 = hum_coeffs[55:40];
    coeff.h6 = hum_coeffs[63:56];
  end

  esc_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(in_valid),
    .raw_t(raw_temperature), .raw_p(raw_pressure), .raw_h(raw_humidity),
    .coeff(coeff), .o_vld(f_vld), .num(f_num), .dv(f_dv), .side(f_side)
  );

  esc_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(f_vld), .num(f_num), .dv(f_dv),
    .side_in(f_side), .o_vld(d_vld), .quo(d_quo), .zero(d_zero), .side(d_side)
  );

  esc_back u_back (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(d_vld), .p(d_quo), .zero(d_zero),
    .side_in(d_side), .coeff(coeff), .o_vld(out_valid),
    .fine_temperature(fine_temperature), .temperature_centi(temperature_centi),
    .pressure_q24_8(pressure_q24_8), .pressure_valid(pressure_valid),
    .humidity_q22_10(humidity_q22_10)
  );

endmodule

// File: test/tb_env_sensor_compensation_top.sv
// testbench for env_sensor_compensation_top: coefficient phases, directed and random samples
// depends on esc_pkg and the rtl in src; scoreboard predicts every result bit-exact
`timescale 1ns / 1ps

module tb_env_sensor_compensation_top;
  import esc_pkg::*;

  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_WAIT = 100;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic signed [31:0] fine;
    logic signed [31:0] centi;
    logic [31:0]        press;
    logic               press_ok;
    logic [16:0]        hum;
  } reading_t;

  class compensation_scoreboard;
    logic [63:0] coeff_reg [6];
    reading_t    pending_q [$];
    int          errors;

    function new();
      foreach (coeff_reg[i]) coeff_reg[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [63:0] data);
      case (idx)
        REG_TEMP:       coeff_reg[0] = {16'd0, data[47:0]};
        REG_PRESS_LOW:  coeff_reg[1] = data;
        REG_PRESS_HIGH: coeff_reg[2] = data;
        REG_PRESS_NINE: coeff_reg[3] = {48'd0, data[15:0]};
        REG_HUM:        coeff_reg[4] = data;
        REG_HUM_ONE:    coeff_reg[5] = {56'd0, data[7:0]};
        default: ;
      endcase
    endfunction

    function longint sfield(int r, int pos, int w);
      logic [63:0] x;
      x = coeff_reg[r] >> pos;
      if (w == 8) return longint'($signed(x[7:0]));
      return longint'($signed(x[15:0]));
    endfunction

    function longint div_trunc(longint num, longint den);
      logic [63:0] mn, md, q;
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      q = mn / md;
      return ((num < 0) != (den < 0)) ? longint'(-q) : longint'(q);
    endfunction

    function reading_t compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint h1, h2, h3, h4, h5, h6;
      longint a, b, d, p, v, tf, adc_t;
      reading_t r;
      adc_t = longint'({44'd0, rt});
      t1 = longint'({48'd0, coeff_reg[0][15:0]});
      t2 = sfield(0, 16, 16);
      t3 = sfield(0, 32, 16);
      p1 = longint'({48'd0, coeff_reg[1][15:0]});
      p2 = sfield(1, 16, 16);
      p3 = sfield(1, 32, 16);
      p4 = sfield(1, 48, 16);
      p5 = sfield(2, 0, 16);
      p6 = sfield(2, 16, 16);
      p7 = sfield(2, 32, 16);
      p8 = sfield(2, 48, 16);
      p9 = sfield(3, 0, 16);
      h1 = longint'({56'd0, coeff_reg[5][7:0]});
      h2 = sfield(4, 0, 16);
      h3 = longint'({56'd0, coeff_reg[4][23:16]});
      h4 = sfield(4, 24, 16);
      h5 = sfield(4, 40, 16);
      h6 = sfield(4, 56, 8);

      a = (((adc_t >> 3) - (t1 <<< 1)) * t2) >>> 11;
      d = (adc_t >> 4) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      tf = a + b;
      if (tf < -64'sd2147483648) tf = -64'sd2147483648;
      if (tf > 64'sd2147483647) tf = 64'sd2147483647;
      r.fine = tf[31:0];
      a = (tf * 5 + 128) >>> 8;
      r.centi = a[31:0];

      a = tf - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      if (a == 0) begin
        r.press = '0;
        r.press_ok = 1'b0;
      end else begin
        p = 1048576 - longint'({44'd0, rp});
        p = div_trunc(((p <<< 31) - b) * 3125, a);
        a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        b = (p8 * p) >>> 19;
        p = ((p + a + b) >>> 8) + (p7 <<< 4);
        if (p < 0) r.press = '0;
        else if (p > 64'sd4294967295) r.press = 32'hFFFF_FFFF;
        else r.press = p[31:0];
        r.press_ok = 1'b1;
      end

      v = tf - 76800;
      a = ((longint'({48'd0, rh}) <<< 14) - (h4 <<< 20) - h5 * v + 16384) >>> 15;
      b = ((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768);
      b = (b >>> 10) + 2097152;
      b = (b * h2 + 8192) >>> 14;
      v = a * b;
      d = v >>> 15;
      v = v - ((((d * d) >>> 7) * h1) >>> 4);
      if (v < 0) v = 0;
      if (v > 419430400) v = 419430400;
      v = v >> 12;
      r.hum = v[16:0];
      return r;
    endfunction

    function void note_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      pending_q.push_back(compensate(rt, rp, rh));
    endfunction

    function void mismatch(string fld, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fld, exp_v, act_v);
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual fine=%0d", $time, got.fine);
        return;
      end
      want = pending_q.pop_front();
      if (got.fine !== want.fine) mismatch("fine_temperature", want.fine, got.fine);
      if (got.centi !== want.centi) mismatch("temperature_centi", want.centi, got.centi);
      if (got.press !== want.press) mismatch("pressure_q24_8", want.press, got.press);
      if (got.press_ok !== want.press_ok)
        mismatch("pressure_valid", want.press_ok, got.press_ok);
      if (got.hum !== want.hum) mismatch("humidity_q22_10", want.hum, got.hum);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure = '0;
  logic [15:0] raw_humidity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] fine_temperature;
  logic signed [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic pressure_valid;
  logic [16:0] humidity_q22_10;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  compensation_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  env_sensor_compensation_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_sample(raw_temperature, raw_pressure, raw_humidity);
    if (!rst && cfg_valid && cfg_ready)
      sb.set_reg(cfg_index, cfg_data);
    if (!rst && out_valid && out_ready)
      sb.check_result('{fine_temperature, temperature_centi, pressure_q24_8,
                        pressure_valid, humidity_q22_10});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side: long hold-off, then random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (!quiet && stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    raw_temperature = rt;
    raw_pressure = rp;
    raw_humidity = rh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [63:0] data);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic load_coeffs(logic [47:0] tc, logic [63:0] pl, logic [63:0] ph,
                             logic [15:0] p9, logic [63:0] hc, logic [7:0] h1);
    wait_idle();
    write_reg(REG_TEMP, {16'hDEAD, tc});
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_HIGH, ph);
    write_reg(REG_PRESS_NINE, {48'hBEEF, p9});
    write_reg(REG_HUM, hc);
    write_reg(REG_HUM_ONE, {56'hA5, h1});
  endtask

  task automatic load_typical();
    load_coeffs({-16'sd1000, 16'sd26435, 16'd27504},
                {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477},
                {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140},
                16'sd6000,
                {8'sd30, 16'sd50, 16'sd313, 8'd0, 16'sd362}, 8'd75);
  endtask

  task automatic load_random();
    load_coeffs(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                16'($urandom), {$urandom, $urandom}, 8'($urandom));
  endtask

  function automatic logic [19:0] near20(int centre, int spread);
    int x;
    x = centre + $urandom_range(0, 2 * spread) - spread;
    if (x < 0) x = 0;
    if (x > 1048575) x = 1048575;
    return x[19:0];
  endfunction

  task automatic random_samples(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0)
        send_sample(near20(519888, 150000), near20(415148, 300000),
                    16'(near20(30000, 25000)));
      else
        send_sample(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  task automatic directed_samples();
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    send_sample(20'h55555, 20'hAAAAA, 16'h5555);
    send_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_sample(20'd519888, 20'd415148, 16'd30000);
    send_sample(20'd440064, 20'd1048575, 16'd65535);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset coefficients: zero pressure divisor
    directed_samples();

    load_typical();
    directed_samples();
    random_samples(150);
    hold_left = LONG_HOLD;
    random_samples(450);

    load_random();
    directed_samples();
    random_samples(300);

    // all-ones, sign-bit and largest-positive extremes
    load_coeffs('1, '1, '1, '1, '1, '1);
    directed_samples();
    random_samples(150);
    load_coeffs({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000,
                64'h80_8000_8000_80_8000, 8'h80);
    directed_samples();
    random_samples(150);
    load_coeffs({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF,
                64'h7F_7FFF_7FFF_FF_7FFF, 8'hFF);
    random_samples(150);

    load_random();
    write_reg(REG_UNUSED, '1);
    random_samples(200);

    load_typical();
    random_samples(200);
    quiet = 1'b1;
    random_samples(150);

    wait_idle();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
